// ----- rtl/core/itoa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the integer to ASCII converter.
package itoa_pkg;

    // Field widths
    localparam int BIN_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int PAD_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // Hex pad clamp; one number never yields more than RESULT_LIMIT characters
    localparam int MAX_PAD_WIDTH = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int PAD_LIMIT     = (MAX_PAD_WIDTH < RESULT_LIMIT) ? MAX_PAD_WIDTH
                                                                  : RESULT_LIMIT;

    // Digit row: ten BCD digits cover any 32-bit value, eight nibbles in hex
    localparam int DIGIT_CELLS = 10;
    localparam int HEX_NIBBLES = BIN_W / DIGIT_W;

    // Counter widths
    localparam int CNT_W  = $clog2(BIN_W + 1);
    localparam int ROW_W  = $clog2(DIGIT_CELLS + 1);
    localparam int LEAD_W = $clog2(RESULT_LIMIT - DIGIT_CELLS + 1);

    // Mode codes
    localparam logic [FUNC_W-1:0] FUNC_UDEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HEX  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SDEC = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;

    // Operation applied to every cell of the digit row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_SHIFT  = 2'd3
    } t_cell_op;

endpackage

// ----- rtl/core/itoa_cell.sv -----
`timescale 1ns / 1ps
// One digit cell of the conversion row: BCD add-3-and-shift, load, digit shift.
module itoa_cell (
    input  logic                          i_clk,
    input  itoa_pkg::t_cell_op            i_op,
    input  logic [itoa_pkg::DIGIT_W-1:0]  i_load,
    input  logic [itoa_pkg::DIGIT_W-1:0]  i_digit_in,
    input  logic                          i_bit_in,
    output logic [itoa_pkg::DIGIT_W-1:0]  o_digit,
    output logic                          o_carry
);

    logic [itoa_pkg::DIGIT_W-1:0] r_digit;
    logic [itoa_pkg::DIGIT_W-1:0] n_digit;
    logic [itoa_pkg::DIGIT_W-1:0] w_adj;

    // Add 3 when the digit would overflow a decade after doubling
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[itoa_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_op)
            itoa_pkg::CELL_LOAD:   n_digit = i_load;
            itoa_pkg::CELL_DABBLE: n_digit = {w_adj[itoa_pkg::DIGIT_W-2:0], i_bit_in};
            itoa_pkg::CELL_SHIFT:  n_digit = i_digit_in;
            default:               n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ----- rtl/core/integer_to_ascii_converter.sv -----
`timescale 1ns / 1ps
// Integer to ASCII converter: control sequencer, digit row and output register.
//
// One number is taken at a time and turned into its ASCII text, most
// significant character first, one character per output transfer with o_last
// on the final one. The value enters a row of ten 4-bit digit cells: in hex
// mode the nibbles load straight in; in decimal modes all 32 bits of the
// magnitude are shifted in one bit per cycle with add-3 correction. Next the
// digit count is found, then the row is shifted up past any unused leading
// cells, a '-' or the hex padding zeros beyond the row are sent, and the digits
// are shifted out of the top cell one per cycle unless the receiver stalls.
// The input is taken only while the block is idle; the last character may
// still wait in the output register when the next number is accepted.
module integer_to_ascii_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [itoa_pkg::BIN_W-1:0]    i_value,
    input  logic [itoa_pkg::FUNC_W-1:0]   i_func,
    input  logic [itoa_pkg::PAD_W-1:0]    i_pad_width,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [itoa_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_LEAD = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [itoa_pkg::BIN_W-1:0]  r_bin, n_bin;
    logic [itoa_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [itoa_pkg::ROW_W-1:0]  r_rows, n_rows;
    logic [itoa_pkg::LEAD_W-1:0] r_lead, n_lead;
    logic [itoa_pkg::PAD_W-1:0]  r_pad, n_pad;
    logic                        r_neg, n_neg;
    logic                        r_hex, n_hex;

    logic                        r_out_valid, n_out_valid;
    logic [itoa_pkg::CHAR_W-1:0] r_char, n_char;
    logic                        r_last, n_last;

    logic                        w_accept;
    logic                        w_can_push;
    logic                        w_push;
    logic                        w_in_neg;
    logic                        w_in_hex;
    logic [itoa_pkg::BIN_W-1:0]  w_mag;
    itoa_pkg::t_cell_op          w_op;

    logic [itoa_pkg::DIGIT_W-1:0] w_digit [itoa_pkg::DIGIT_CELLS];
    logic                         w_carry [itoa_pkg::DIGIT_CELLS];
    logic [itoa_pkg::DIGIT_W-1:0] w_top;
    logic [itoa_pkg::CHAR_W-1:0]  w_top_char;

    logic [itoa_pkg::ROW_W-1:0]  w_nd;
    logic [itoa_pkg::PAD_W-1:0]  w_ntot;
    logic [itoa_pkg::CNT_W-1:0]  w_skip;
    logic [itoa_pkg::ROW_W-1:0]  w_rowcnt;
    logic [itoa_pkg::LEAD_W-1:0] w_lead;

    // Handshakes
    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_can_push = !r_out_valid || !i_stall;
    assign w_push     = ((r_state == S_LEAD) || (r_state == S_EMIT)) && w_can_push;

    // Sign and magnitude of the incoming number
    assign w_in_hex = (i_func == itoa_pkg::FUNC_HEX);
    assign w_in_neg = (i_func == itoa_pkg::FUNC_SDEC) && i_value[itoa_pkg::BIN_W-1];
    assign w_mag    = w_in_neg ? (~i_value + 32'd1) : i_value;

    // Digit row
    genvar g;
    generate
        for (g = 0; g < itoa_pkg::DIGIT_CELLS; g++) begin : g_cell
            logic [itoa_pkg::DIGIT_W-1:0] w_load;
            logic [itoa_pkg::DIGIT_W-1:0] w_din;
            logic                         w_bin;

            if (g < itoa_pkg::HEX_NIBBLES) begin : g_nib
                assign w_load = w_in_hex ? w_mag[g*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W]
                                         : '0;
            end else begin : g_nonib
                assign w_load = '0;
            end

            if (g == 0) begin : g_first
                assign w_din = '0;
                assign w_bin = r_bin[itoa_pkg::BIN_W-1];
            end else begin : g_next
                assign w_din = w_digit[g-1];
                assign w_bin = w_carry[g-1];
            end

            itoa_cell u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op),
                .i_load     (w_load),
                .i_digit_in (w_din),
                .i_bit_in   (w_bin),
                .o_digit    (w_digit[g]),
                .o_carry    (w_carry[g])
            );
        end
    endgenerate

    // Top cell as an ASCII character
    assign w_top      = w_digit[itoa_pkg::DIGIT_CELLS-1];
    assign w_top_char = (w_top < itoa_pkg::DEC_BASE)
                      ? (itoa_pkg::CHAR_ZERO + {4'd0, w_top})
                      : (itoa_pkg::CHAR_UPA + {4'd0, w_top - itoa_pkg::DEC_BASE});

    // Significant digit count, at least one
    always_comb begin
        w_nd = itoa_pkg::ROW_W'(1);
        for (int i = 0; i < itoa_pkg::DIGIT_CELLS; i++) begin
            if (w_digit[i] != '0) begin
                w_nd = itoa_pkg::ROW_W'(i + 1);
            end
        end
    end

    // Character count, row cells to skip and leading characters
    always_comb begin
        if (r_hex && (r_pad > itoa_pkg::PAD_W'(w_nd))) begin
            w_ntot = r_pad;
        end else begin
            w_ntot = itoa_pkg::PAD_W'(w_nd);
        end
        if (w_ntot >= itoa_pkg::PAD_W'(itoa_pkg::DIGIT_CELLS)) begin
            w_skip   = '0;
            w_rowcnt = itoa_pkg::ROW_W'(itoa_pkg::DIGIT_CELLS);
            w_lead   = r_hex ? itoa_pkg::LEAD_W'(w_ntot - itoa_pkg::PAD_W'(itoa_pkg::DIGIT_CELLS))
                             : itoa_pkg::LEAD_W'(r_neg);
        end else begin
            w_skip   = itoa_pkg::CNT_W'(itoa_pkg::PAD_W'(itoa_pkg::DIGIT_CELLS) - w_ntot);
            w_rowcnt = itoa_pkg::ROW_W'(w_ntot);
            w_lead   = itoa_pkg::LEAD_W'(r_neg);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_rows      = r_rows;
        n_lead      = r_lead;
        n_pad       = r_pad;
        n_neg       = r_neg;
        n_hex       = r_hex;
        n_char      = r_char;
        n_last      = r_last;
        w_op        = itoa_pkg::CELL_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_op    = itoa_pkg::CELL_LOAD;
                    n_bin   = w_mag;
                    n_neg   = w_in_neg;
                    n_hex   = w_in_hex;
                    n_pad   = (i_pad_width > itoa_pkg::PAD_W'(itoa_pkg::PAD_LIMIT))
                            ? itoa_pkg::PAD_W'(itoa_pkg::PAD_LIMIT) : i_pad_width;
                    n_cnt   = w_in_hex ? '0 : itoa_pkg::CNT_W'(itoa_pkg::BIN_W);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (r_cnt != '0) begin
                    // one bit of the magnitude into the BCD row
                    w_op  = itoa_pkg::CELL_DABBLE;
                    n_bin = {r_bin[itoa_pkg::BIN_W-2:0], 1'b0};
                    n_cnt = r_cnt - itoa_pkg::CNT_W'(1);
                end else begin
                    n_cnt  = w_skip;
                    n_rows = w_rowcnt;
                    n_lead = w_lead;
                    if (w_skip != '0) begin
                        n_state = S_SKIP;
                    end else if (w_lead != '0) begin
                        n_state = S_LEAD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SKIP: begin
                // drop unused leading cells off the top
                w_op  = itoa_pkg::CELL_SHIFT;
                n_cnt = r_cnt - itoa_pkg::CNT_W'(1);
                if (r_cnt == itoa_pkg::CNT_W'(1)) begin
                    n_state = (r_lead != '0) ? S_LEAD : S_EMIT;
                end
            end
            S_LEAD: begin
                if (w_can_push) begin
                    n_char = r_hex ? itoa_pkg::CHAR_ZERO : itoa_pkg::CHAR_MINUS;
                    n_last = 1'b0;
                    n_lead = r_lead - itoa_pkg::LEAD_W'(1);
                    if (r_lead == itoa_pkg::LEAD_W'(1)) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_can_push) begin
                    w_op   = itoa_pkg::CELL_SHIFT;
                    n_char = w_top_char;
                    n_last = (r_rows == itoa_pkg::ROW_W'(1));
                    n_rows = r_rows - itoa_pkg::ROW_W'(1);
                    if (r_rows == itoa_pkg::ROW_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (w_push) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_rows <= n_rows;
        r_lead <= n_lead;
        r_pad  <= n_pad;
        r_neg  <= n_neg;
        r_hex  <= n_hex;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the integer to ASCII converter, with a scoreboard and random traffic.
module tb_top;
    import itoa_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;  // undefined mode, behaves as FUNC_UDEC
    localparam int                RANDOM_ITEMS = 127;
    localparam int                IDLE_LIMIT   = 3000;  // cycles with no transfer on either side
    localparam int                LONG_HOLD    = 300;
    localparam int                DRAIN_CYCLES = 64;

    // One character of converted text
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    // Scoreboard: spells each accepted number and checks characters in order
    class itoa_checker;
        t_text_char expected_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Work out the text of one accepted number
        function void note_number(logic [BIN_W-1:0] value, logic [FUNC_W-1:0] func,
                                  logic [PAD_W-1:0] pad);
            logic [CHAR_W-1:0] digits[$];   // least significant first
            logic [BIN_W-1:0]  mag;
            logic [3:0]        nib;
            logic              neg;
            logic              hex;
            int                eff_pad;
            t_text_char        c;
            hex = (func == FUNC_HEX);
            neg = (func == FUNC_SDEC) && value[BIN_W-1];
            mag = neg ? (~value + 1'b1) : value;
            // hex pad saturates at the parameter and at the per-number character limit
            eff_pad = pad;
            if (eff_pad > MAX_PAD_WIDTH) eff_pad = MAX_PAD_WIDTH;
            if (eff_pad > RESULT_LIMIT) eff_pad = RESULT_LIMIT;
            if (mag == '0) begin
                digits.push_back(CHAR_ZERO);
            end else if (hex) begin
                while (mag != '0) begin
                    nib = mag[3:0];
                    digits.push_back(nib < DEC_BASE ? CHAR_ZERO + CHAR_W'(nib)
                                                    : CHAR_UPA + CHAR_W'(nib - DEC_BASE));
                    mag = mag >> 4;
                end
            end else begin
                while (mag != '0) begin
                    digits.push_back(CHAR_ZERO + CHAR_W'(mag % BIN_W'(DEC_BASE)));
                    mag = mag / BIN_W'(DEC_BASE);
                end
            end
            if (hex) begin
                while (digits.size() < eff_pad) digits.push_back(CHAR_ZERO);
            end
            if (neg) begin
                c.code = CHAR_MINUS;
                c.last = 1'b0;
                expected_chars.push_back(c);
            end
            for (int k = digits.size() - 1; k >= 0; k--) begin
                c.code = digits[k];
                c.last = (k == 0);
                expected_chars.push_back(c);
            end
        endfunction

        // Compare one output transfer with the oldest expected character
        function void check_char(logic [CHAR_W-1:0] code, logic last);
            t_text_char e;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character %h last %b with nothing pending", code, last);
                return;
            end
            e = expected_chars.pop_front();
            if (code !== e.code || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected char %h last %b, got char %h last %b",
                             e.code, e.last, code, last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [BIN_W-1:0]  i_value     = '0;
    logic [FUNC_W-1:0] i_func      = FUNC_UDEC;
    logic [PAD_W-1:0]  i_pad_width = '0;
    logic              i_stall     = 1'b1;
    logic              o_stall;
    logic              o_valid;
    logic [CHAR_W-1:0] o_char_code;
    logic              o_last;

    itoa_checker book = new();
    int          numbers_sent = 0;
    int          burst_left   = 0;
    bit          long_hold_done = 1'b0;

    integer_to_ascii_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_func      (i_func),
        .i_pad_width (i_pad_width),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Offer one number, with bursts and gaps between them, and wait for its transfer
    task automatic send_number(input logic [BIN_W-1:0] value, input logic [FUNC_W-1:0] func,
                               input logic [PAD_W-1:0] pad);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_value     <= value;
        i_func      <= func;
        i_pad_width <= pad;
        do @(posedge i_clk); while (o_stall);
        book.note_number(value, func, pad);
        numbers_sent++;
    endtask

    // Random number drawn from several value classes
    function automatic logic [BIN_W-1:0] pick_value();
        logic [BIN_W-1:0] p;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 15);
            2: begin
                // near a power of ten, where the digit count changes
                p = 1;
                repeat ($urandom_range(1, 9)) p = p * 10;
                return p + $urandom_range(0, 2) - 1;
            end
            3: return 32'h8000_0000 | $urandom;
            4: return -BIN_W'($urandom_range(1, 100));
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            book.check_char(o_char_code, o_last);
    end

    // Receiver stall pattern, with one long hold once traffic is under way
    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && numbers_sent >= 40) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transfer happens for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                idle = 0;
            else
                idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence
    initial begin
        logic [FUNC_W-1:0] f;
        int                sel;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero and extremes in every mode
        send_number(32'h0000_0000, FUNC_UDEC, 5'd0);
        send_number(32'h0000_0000, FUNC_HEX, 5'd0);
        send_number(32'h0000_0000, FUNC_SDEC, 5'd0);
        send_number(32'h0000_0000, FUNC_SPARE, 5'd0);
        send_number(32'hFFFF_FFFF, FUNC_UDEC, 5'd31);
        send_number(32'hFFFF_FFFF, FUNC_HEX, 5'd0);
        send_number(32'hFFFF_FFFF, FUNC_SDEC, 5'd0);
        send_number(32'hFFFF_FFFF, FUNC_SPARE, 5'd16);
        // most negative and most positive signed values
        send_number(32'h8000_0000, FUNC_SDEC, 5'd0);
        send_number(32'h7FFF_FFFF, FUNC_SDEC, 5'd0);
        send_number(32'h8000_0000, FUNC_UDEC, 5'd0);
        send_number(32'h0000_0001, FUNC_SDEC, 5'd0);
        // hex padding: full, saturating, too narrow, exact
        send_number(32'h0000_0000, FUNC_HEX, 5'd16);
        send_number(32'h0000_00AB, FUNC_HEX, 5'd31);
        send_number(32'h0000_00AB, FUNC_HEX, 5'd17);
        send_number(32'h0001_2345, FUNC_HEX, 5'd3);
        send_number(32'hABCD_EF01, FUNC_HEX, 5'd8);
        send_number(32'h0000_000F, FUNC_HEX, 5'd1);
        send_number(32'h0000_0009, FUNC_UDEC, 5'd0);
        send_number(32'h0000_000A, FUNC_UDEC, 5'd0);
        send_number(32'd1000000000, FUNC_UDEC, 5'd0);
        send_number(32'd999999999, FUNC_SPARE, 5'd0);
        send_number(32'h5A5A_A5A5, FUNC_SDEC, 5'd21);

        // random traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 11);
            f   = (sel == 11) ? FUNC_SPARE : FUNC_W'(sel % 3);
            send_number(pick_value(), f, PAD_W'($urandom_range(0, 31)));
        end
        i_valid <= 1'b0;

        // drain
        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
